@@ hdl/fifo_queue_with_sum_average_assert.svh @@
// assertion macros for the fifo queue with running sum and average
// plain text macros only, no dependencies; assertions drop out when SYNTH is set
`ifndef FIFO_QUEUE_WITH_SUM_AVERAGE_ASSERT_SVH
`define FIFO_QUEUE_WITH_SUM_AVERAGE_ASSERT_SVH

`ifndef SYNTH

// condition holds at every edge outside reset
`define FQSA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define FQSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define FQSA_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define FQSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ hdl/fqsa_pkg.sv @@
// types and fixed constants of the fifo queue with running sum and average
// no dependencies
`default_nettype none

package fqsa_pkg;

   localparam int WORD_W   = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_QUERY   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_HOLD   = 4'b1000
   } state_type;

endpackage

`default_nettype wire

@@ hdl/fifo_queue_with_sum_average.sv @@
// fifo queue of signed words with running sum and serial average divider
// depends on fqsa_pkg and fifo_queue_with_sum_average_assert.svh
`default_nettype none

// Bounded fifo of signed 32-bit words kept in a one-port-write, one-port-read
// synchronous ram. Each request item (op in tuser, word in tdata) yields one
// response item with status, popped word, entry count, running sum, average
// and full/empty flags. One item at a time is in work: an enqueue, clear or
// query passes through the divide state to the hold state, where its response
// is loaded; a dequeue first passes through a read state for the ram read. The
// restoring divider produces the average one quotient bit per cycle over
// the SUM_W bits of the sum. The response sits in an output register, so the
// next request is taken while it waits. The ram has no reset and needs no
// clearing pass.

`include "fifo_queue_with_sum_average_assert.svh"

module fifo_queue_with_sum_average
   import fqsa_pkg::*;
#(
   parameter int QUEUE_DEPTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [WORD_W-1:0]    req_tdata,   // value_in
   input  wire logic [OP_W-1:0]      req_tuser,   // op
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // value_out, entry_count, entry_sum, entry_average, is_full, is_empty, zero pad
   output logic [((2*WORD_W + $clog2(QUEUE_DEPTH+1) + WORD_W + $clog2(QUEUE_DEPTH)
                  + 2 + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic [STATUS_W-1:0]       rsp_tuser    // status
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = WORD_W + $clog2(QUEUE_DEPTH);
   localparam int SLOT_W = PTR_W + 1;
   localparam int STEP_W = $clog2(SUM_W);
   localparam int RAW_W  = 2 * WORD_W + CNT_W + SUM_W + 2;
   localparam int RSP_W  = ((RAW_W + 7) / 8) * 8;

   state_type                state_ff, state_in;
   logic [PTR_W-1:0]         rp_ff, rp_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   status_type               status_ff, status_in;
   logic signed [WORD_W-1:0] popped_ff, popped_in;

   // divider: dvd holds the dividend and shifts the quotient in from the bottom
   logic                     neg_ff, neg_in;
   logic [SUM_W-1:0]         dvd_ff, dvd_in;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     div_start;
   logic [CNT_W:0]           trial;
   logic [CNT_W:0]           trial_diff;
   logic                     qbit;

   // word ram
   logic [WORD_W-1:0]        mem [QUEUE_DEPTH];
   logic                     wr_en;
   logic [PTR_W-1:0]         wr_addr;
   logic                     rd_en;
   logic [PTR_W-1:0]         rd_addr;
   logic [WORD_W-1:0]        rd_data_ff;
   logic [SLOT_W-1:0]        slot_sum;

   // response register
   logic                     rsp_load;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff;
   logic [WORD_W-1:0]        rsp_value_ff;
   logic [CNT_W-1:0]         rsp_count_ff;
   logic [SUM_W-1:0]         rsp_sum_ff;
   logic [WORD_W-1:0]        rsp_avg_ff;
   logic                     rsp_full_ff;
   logic                     rsp_empty_ff;
   logic [WORD_W-1:0]        quot;
   logic [WORD_W-1:0]        avg;

   op_type                   op;
   logic                     accept;

   assign op       = op_type'(req_tuser);
   assign accept   = req_tvalid && req_tready;

   // tail slot, rp + count wrapped at the depth
   assign slot_sum = SLOT_W'(rp_ff) + SLOT_W'(count_ff);
   assign wr_addr  = (slot_sum >= SLOT_W'(QUEUE_DEPTH))
                     ? PTR_W'(slot_sum - SLOT_W'(QUEUE_DEPTH)) : PTR_W'(slot_sum);
   assign rd_addr  = rp_ff;

   assign trial      = {rem_ff, dvd_ff[SUM_W-1]};
   assign trial_diff = trial - {1'b0, count_ff};
   assign qbit       = (trial >= {1'b0, count_ff});

   assign quot = dvd_ff[WORD_W-1:0];
   assign avg  = (count_ff == '0) ? '0 : (neg_ff ? (~quot + 1'b1) : quot);

   always_comb begin
      state_in   = state_ff;
      rp_in      = rp_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      status_in  = status_ff;
      popped_in  = popped_ff;
      neg_in     = neg_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      div_start  = 1'b0;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      rsp_load   = 1'b0;
      req_tready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               status_in = STATUS_DONE;
               popped_in = '0;
               state_in  = ST_DIVIDE;
               div_start = 1'b1;
               unique case (op)
                  OP_ENQUEUE: begin
                     if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                        sum_in   = sum_ff + SUM_W'(signed'(req_tdata));
                     end
                  end
                  OP_DEQUEUE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        // word arrives next cycle, sum is fixed up there
                        rd_en     = 1'b1;
                        rp_in     = (rp_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
                        count_in  = count_ff - 1'b1;
                        div_start = 1'b0;
                        state_in  = ST_READ;
                     end
                  end
                  OP_CLEAR: begin
                     rp_in    = '0;
                     count_in = '0;
                     sum_in   = '0;
                  end
                  OP_QUERY: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            popped_in = signed'(rd_data_ff);
            sum_in    = sum_ff - SUM_W'(signed'(rd_data_ff));
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            rem_in  = qbit ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
            dvd_in  = {dvd_ff[SUM_W-2:0], qbit};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (div_start) begin
         neg_in  = sum_in[SUM_W-1];
         dvd_in  = sum_in[SUM_W-1] ? unsigned'(-sum_in) : unsigned'(sum_in);
         rem_in  = '0;
         step_in = '0;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rp_ff        <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      popped_ff <= popped_in;
      neg_ff    <= neg_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      step_ff   <= step_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= popped_ff;
         rsp_count_ff  <= count_ff;
         rsp_sum_ff    <= sum_ff;
         rsp_avg_ff    <= avg;
         rsp_full_ff   <= (count_ff == CNT_W'(QUEUE_DEPTH));
         rsp_empty_ff  <= (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_tdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_W'({rsp_empty_ff, rsp_full_ff, rsp_avg_ff, rsp_sum_ff,
                               rsp_count_ff, rsp_value_ff});

   `FQSA_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(QUEUE_DEPTH),
      "count above depth")
   // while a dequeue reads the ram, the sum is fixed up the cycle after the count
   `FQSA_ASSERT_ALWAYS(a_empty_sum, clock, reset,
      (state_ff == ST_READ) || (count_ff != '0) || (sum_ff == '0),
      "empty queue with nonzero sum")
   `FQSA_ASSERT_NEXT(a_clear, clock, reset, accept && (op == OP_CLEAR),
      (count_ff == '0) && (rp_ff == '0) && (sum_ff == '0), "clear left state behind")
   `FQSA_ASSERT_NEXT(a_enqueue, clock, reset,
      accept && (op == OP_ENQUEUE) && (count_ff != CNT_W'(QUEUE_DEPTH)),
      count_ff == $past(count_ff) + 1'b1, "enqueue did not grow count")
   `FQSA_ASSERT_ALWAYS(a_empty_rsp, clock, reset,
      !rsp_valid_ff || (rsp_count_ff != '0) || ((rsp_avg_ff == '0) && rsp_empty_ff),
      "empty response with nonzero average")

endmodule

`default_nettype wire
